// ===== hdl/rational_accumulator_alu_unit_assert.svh =====
// Assertion macros used by the checker file.
// Each macro samples on the rising edge of clk and is off while rst_n is low.
`ifndef RATIONAL_ACCUMULATOR_ALU_UNIT_ASSERT_SVH
`define RATIONAL_ACCUMULATOR_ALU_UNIT_ASSERT_SVH

// Same-cycle implication.
`define RAA_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("rational accumulator check failed");

// Next-cycle implication.
`define RAA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("rational accumulator check failed");

`endif

// ===== hdl/raa_pkg.sv =====
package raa_pkg;

    // Widths of the transaction fields
    localparam int CMD_W = 3;
    localparam int IO_W  = 32;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_LOAD   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SUB    = 3'd2;
    localparam logic [CMD_W-1:0] CMD_MUL    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_DIV    = 3'd4;
    localparam logic [CMD_W-1:0] CMD_REDUCE = 3'd5;

    // Shared unit control and status
    typedef struct packed {
        logic start;
        logic div_op;
    } raa_unit_ctrl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } raa_unit_stat_t;

endpackage

// ===== hdl/raa_if.sv =====
interface raa_req_if;
    import raa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic [CMD_W-1:0]        command;
    logic signed [IO_W-1:0]  operand_num;
    logic signed [IO_W-1:0]  operand_den;

    modport source (output valid, command, operand_num, operand_den, input ready);
    modport sink   (input valid, command, operand_num, operand_den, output ready);
endinterface

interface raa_rsp_if;
    import raa_pkg::*;

    logic                    valid;
    logic                    ready;
    logic signed [IO_W-1:0]  result_num;
    logic signed [IO_W-1:0]  result_den;
    logic                    overflow;
    logic                    zero_den_error;

    modport source (output valid, result_num, result_den, overflow, zero_den_error,
                    input ready);
    modport sink   (input valid, result_num, result_den, overflow, zero_den_error,
                    output ready);
endinterface

// ===== hdl/raa_iter_unit.sv =====
// Shared shift/add unit: unsigned shift-add multiply or restoring divide,
// one bit per cycle on a single WIDTH+1 bit adder.
module raa_iter_unit #(
    parameter int WIDTH = 32
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  raa_pkg::raa_unit_ctrl_t ctrl,
    input  logic [WIDTH-1:0]        a_in,
    input  logic [WIDTH-1:0]        b_in,
    output raa_pkg::raa_unit_stat_t stat,
    output logic [WIDTH-1:0]        hi_out,
    output logic [WIDTH-1:0]        lo_out
);
    import raa_pkg::*;

    localparam int CW = $clog2(WIDTH + 1);

    logic [WIDTH-1:0] hi_reg, hi_next;
    logic [WIDTH-1:0] lo_reg, lo_next;
    logic [WIDTH-1:0] b_reg, b_next;
    logic             div_reg, div_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             done_reg, done_next;

    logic [WIDTH:0]   x_ext;
    logic [WIDTH:0]   y_ext;
    logic [WIDTH:0]   sum;

    // One adder: hi + b (when lo[0] is set) for multiply, shifted remainder - b for divide
    always_comb
    begin
        x_ext = div_reg ? {hi_reg, lo_reg[WIDTH-1]} : {1'b0, hi_reg};
        if (div_reg)
        begin
            y_ext = ~{1'b0, b_reg};
        end
        else if (lo_reg[0])
        begin
            y_ext = {1'b0, b_reg};
        end
        else
        begin
            y_ext = '0;
        end
        sum = x_ext + y_ext + {{WIDTH{1'b0}}, div_reg};
    end

    // Iteration control
    always_comb
    begin
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        b_next    = b_reg;
        div_next  = div_reg;
        cnt_next  = cnt_reg;
        done_next = (cnt_reg == CW'(1)) && !ctrl.start;
        if (ctrl.start)
        begin
            hi_next  = '0;
            lo_next  = a_in;
            b_next   = b_in;
            div_next = ctrl.div_op;
            cnt_next = CW'(WIDTH);
        end
        else if (cnt_reg != '0)
        begin
            cnt_next = cnt_reg - CW'(1);
            if (div_reg)
            begin
                if (!sum[WIDTH])
                begin
                    hi_next = sum[WIDTH-1:0];
                    lo_next = {lo_reg[WIDTH-2:0], 1'b1};
                end
                else
                begin
                    hi_next = x_ext[WIDTH-1:0];
                    lo_next = {lo_reg[WIDTH-2:0], 1'b0};
                end
            end
            else
            begin
                hi_next = sum[WIDTH:1];
                lo_next = {sum[0], lo_reg[WIDTH-1:1]};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            div_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            div_reg  <= div_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hi_reg <= hi_next;
        lo_reg <= lo_next;
        b_reg  <= b_next;
    end

    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;
    assign hi_out    = hi_reg;
    assign lo_out    = lo_reg;

endmodule

// ===== hdl/rational_accumulator_alu_unit.sv =====
// Rational accumulator ALU.
// Holds one signed fraction num/den (WIDTH bits each), reset to 0/1.
// req channel: command (load, add, sub, mul, div, reduce) and an operand
// fraction. rsp channel: one transaction per request with the accumulator
// after the command plus overflow and zero_den_error flags.
// Commands are served one at a time; req.ready is high only when idle.
// All products and quotients run on one shared shift/add unit, one bit per
// cycle. Load, unused codes and reduce of 0/x or x/0 skip the unit;
// multiply and divide form two products on it, add and subtract three
// (two cross products and the new denominator); reduce runs one divide per
// Euclid remainder step, then divides num and den by the GCD.
// A new request is taken the cycle after the result is registered, even
// while that result waits on a stalled rsp.ready; a second finished result
// waits inside until the output register frees.
// Reset (rst_n low, asynchronous) clears the accumulator to 0/1 and drops
// any pending result.
module rational_accumulator_alu_unit #(
    parameter int WIDTH = 32
) (
    input  logic      clk,
    input  logic      rst_n,
    raa_req_if.sink   req,
    raa_rsp_if.source rsp
);
    import raa_pkg::*;

    // Sequencer states
    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_DISPATCH  = 4'd1;
    localparam logic [3:0] S_MUL_START = 4'd2;
    localparam logic [3:0] S_MUL_WAIT  = 4'd3;
    localparam logic [3:0] S_COMBINE   = 4'd4;
    localparam logic [3:0] S_GCD_START = 4'd5;
    localparam logic [3:0] S_GCD_WAIT  = 4'd6;
    localparam logic [3:0] S_QUO_START = 4'd7;
    localparam logic [3:0] S_QUO_WAIT  = 4'd8;
    localparam logic [3:0] S_FINISH    = 4'd9;

    logic [3:0]             state_reg, state_next;
    logic [CMD_W-1:0]       cmd_reg, cmd_next;
    logic [WIDTH-1:0]       opn_reg, opn_next;
    logic [WIDTH-1:0]       opd_reg, opd_next;
    logic [WIDTH-1:0]       acc_num_reg, acc_num_next;
    logic [WIDTH-1:0]       acc_den_reg, acc_den_next;
    logic [WIDTH-1:0]       res_num_reg, res_num_next;
    logic [WIDTH-1:0]       res_den_reg, res_den_next;
    logic [WIDTH-1:0]       prod_reg [3];
    logic [WIDTH-1:0]       prod_next [3];
    logic [1:0]             k_reg, k_next;
    logic                   neg_reg, neg_next;
    logic                   ov_reg, ov_next;
    logic                   zerr_reg, zerr_next;
    logic [WIDTH-1:0]       ga_reg, ga_next;
    logic [WIDTH-1:0]       gb_reg, gb_next;
    logic                   rsp_valid_reg, rsp_valid_next;
    logic signed [IO_W-1:0] rsp_num_reg, rsp_num_next;
    logic signed [IO_W-1:0] rsp_den_reg, rsp_den_next;
    logic                   rsp_ov_reg, rsp_ov_next;
    logic                   rsp_zerr_reg, rsp_zerr_next;

    raa_unit_ctrl_t         unit_ctrl;
    raa_unit_stat_t         unit_stat;
    logic [WIDTH-1:0]       unit_a;
    logic [WIDTH-1:0]       unit_b;
    logic [WIDTH-1:0]       unit_hi;
    logic [WIDTH-1:0]       unit_lo;

    logic [WIDTH-1:0]       on_conv;
    logic [WIDTH-1:0]       od_conv;
    logic                   fit_n;
    logic                   fit_d;
    logic [WIDTH-1:0]       left_op;
    logic [WIDTH-1:0]       right_op;
    logic [WIDTH-1:0]       prod_low;
    logic [WIDTH-1:0]       limit;
    logic                   prod_ovf;
    logic [WIDTH-1:0]       comb_sum;
    logic [WIDTH-1:0]       quo_src;
    logic [WIDTH-1:0]       quo_val;
    logic [1:0]             k_last;
    logic                   is_addsub;

    function automatic logic [WIDTH-1:0] neg_f(input logic [WIDTH-1:0] v);
        neg_f = ~v + {{(WIDTH-1){1'b0}}, 1'b1};
    endfunction

    function automatic logic [WIDTH-1:0] mag_f(input logic [WIDTH-1:0] v);
        mag_f = v[WIDTH-1] ? neg_f(v) : v;
    endfunction

    raa_iter_unit #(
        .WIDTH (WIDTH)
    ) u_iter (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (unit_ctrl),
        .a_in   (unit_a),
        .b_in   (unit_b),
        .stat   (unit_stat),
        .hi_out (unit_hi),
        .lo_out (unit_lo)
    );

    // Operand resize to WIDTH; a load flags operands that do not fit
    always_comb
    begin
        on_conv = WIDTH'(req.operand_num);
        od_conv = WIDTH'(req.operand_den);
        fit_n   = (IO_W'($signed(on_conv)) == req.operand_num);
        fit_d   = (IO_W'($signed(od_conv)) == req.operand_den);
    end

    // Operand routing and product post-processing
    always_comb
    begin
        is_addsub = (cmd_reg == CMD_ADD) || (cmd_reg == CMD_SUB);
        k_last    = is_addsub ? 2'd2 : 2'd1;
        left_op   = (k_reg == 2'd0) ? acc_num_reg : acc_den_reg;
        if ((cmd_reg == CMD_MUL) ? (k_reg == 2'd0) : (k_reg == 2'd1))
        begin
            right_op = opn_reg;
        end
        else
        begin
            right_op = opd_reg;
        end
        // signed low word and range check of the magnitude product
        prod_low = neg_reg ? neg_f(unit_lo) : unit_lo;
        limit    = {neg_reg, {(WIDTH-1){~neg_reg}}};
        prod_ovf = (unit_hi != '0) || (unit_lo > limit);
        // cross-product sum or difference
        if (cmd_reg == CMD_SUB)
        begin
            comb_sum = prod_reg[0] - prod_reg[1];
        end
        else
        begin
            comb_sum = prod_reg[0] + prod_reg[1];
        end
        quo_src = (k_reg == 2'd0) ? acc_num_reg : acc_den_reg;
        quo_val = quo_src[WIDTH-1] ? neg_f(unit_lo) : unit_lo;
    end

    // Sequencer
    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        opn_next       = opn_reg;
        opd_next       = opd_reg;
        acc_num_next   = acc_num_reg;
        acc_den_next   = acc_den_reg;
        res_num_next   = res_num_reg;
        res_den_next   = res_den_reg;
        prod_next      = prod_reg;
        k_next         = k_reg;
        neg_next       = neg_reg;
        ov_next        = ov_reg;
        zerr_next      = zerr_reg;
        ga_next        = ga_reg;
        gb_next        = gb_reg;
        rsp_valid_next = rsp_valid_reg;
        rsp_num_next   = rsp_num_reg;
        rsp_den_next   = rsp_den_reg;
        rsp_ov_next    = rsp_ov_reg;
        rsp_zerr_next  = rsp_zerr_reg;
        unit_ctrl      = '0;
        unit_a         = '0;
        unit_b         = '0;

        if (rsp_valid_reg && rsp.ready)
        begin
            rsp_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next     = req.command;
                    opn_next     = on_conv;
                    opd_next     = od_conv;
                    ov_next      = (req.command == CMD_LOAD) && !(fit_n && fit_d);
                    zerr_next    = 1'b0;
                    k_next       = 2'd0;
                    res_num_next = acc_num_reg;
                    res_den_next = acc_den_reg;
                    state_next   = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                case (cmd_reg)
                    CMD_LOAD:
                    begin
                        res_num_next = opn_reg;
                        res_den_next = opd_reg;
                        state_next   = S_FINISH;
                    end
                    CMD_ADD, CMD_SUB, CMD_MUL, CMD_DIV:
                    begin
                        state_next = S_MUL_START;
                    end
                    CMD_REDUCE:
                    begin
                        if (acc_den_reg == '0)
                        begin
                            zerr_next  = 1'b1;
                            state_next = S_FINISH;
                        end
                        else if (acc_num_reg == '0)
                        begin
                            res_num_next = '0;
                            res_den_next = {{(WIDTH-1){1'b0}}, 1'b1};
                            state_next   = S_FINISH;
                        end
                        else
                        begin
                            ga_next    = mag_f(acc_num_reg);
                            gb_next    = mag_f(acc_den_reg);
                            state_next = S_GCD_START;
                        end
                    end
                    default:
                    begin
                        state_next = S_FINISH;
                    end
                endcase
            end
            S_MUL_START:
            begin
                unit_ctrl.start = 1'b1;
                unit_a          = mag_f(left_op);
                unit_b          = mag_f(right_op);
                neg_next        = left_op[WIDTH-1] ^ right_op[WIDTH-1];
                state_next      = S_MUL_WAIT;
            end
            S_MUL_WAIT:
            begin
                if (unit_stat.done)
                begin
                    prod_next[k_reg] = prod_low;
                    ov_next          = ov_reg | prod_ovf;
                    if (k_reg == k_last)
                    begin
                        state_next = S_COMBINE;
                    end
                    else
                    begin
                        k_next     = k_reg + 2'd1;
                        state_next = S_MUL_START;
                    end
                end
            end
            S_COMBINE:
            begin
                if (is_addsub)
                begin
                    res_num_next = comb_sum;
                    res_den_next = prod_reg[2];
                    // operand signs that can wrap differ between add and subtract
                    if (((prod_reg[0][WIDTH-1] == prod_reg[1][WIDTH-1]) ==
                         (cmd_reg == CMD_ADD)) &&
                        (comb_sum[WIDTH-1] != prod_reg[0][WIDTH-1]))
                    begin
                        ov_next = 1'b1;
                    end
                end
                else
                begin
                    res_num_next = prod_reg[0];
                    res_den_next = prod_reg[1];
                end
                state_next = S_FINISH;
            end
            S_GCD_START:
            begin
                unit_ctrl.start  = 1'b1;
                unit_ctrl.div_op = 1'b1;
                unit_a           = ga_reg;
                unit_b           = gb_reg;
                state_next       = S_GCD_WAIT;
            end
            S_GCD_WAIT:
            begin
                if (unit_stat.done)
                begin
                    ga_next = gb_reg;
                    gb_next = unit_hi;
                    if (unit_hi == '0)
                    begin
                        k_next     = 2'd0;
                        state_next = S_QUO_START;
                    end
                    else
                    begin
                        state_next = S_GCD_START;
                    end
                end
            end
            S_QUO_START:
            begin
                unit_ctrl.start  = 1'b1;
                unit_ctrl.div_op = 1'b1;
                unit_a           = mag_f(quo_src);
                unit_b           = ga_reg;
                state_next       = S_QUO_WAIT;
            end
            S_QUO_WAIT:
            begin
                if (unit_stat.done)
                begin
                    if (k_reg == 2'd0)
                    begin
                        res_num_next = quo_val;
                        k_next       = 2'd1;
                        state_next   = S_QUO_START;
                    end
                    else
                    begin
                        res_den_next = quo_val;
                        state_next   = S_FINISH;
                    end
                end
            end
            S_FINISH:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    acc_num_next   = res_num_reg;
                    acc_den_next   = res_den_reg;
                    rsp_valid_next = 1'b1;
                    rsp_num_next   = IO_W'($signed(res_num_reg));
                    rsp_den_next   = IO_W'($signed(res_den_reg));
                    rsp_ov_next    = ov_reg;
                    rsp_zerr_next  = zerr_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            acc_num_reg   <= '0;
            acc_den_reg   <= {{(WIDTH-1){1'b0}}, 1'b1};
            rsp_valid_reg <= 1'b0;
            k_reg         <= 2'd0;
        end
        else
        begin
            state_reg     <= state_next;
            acc_num_reg   <= acc_num_next;
            acc_den_reg   <= acc_den_next;
            rsp_valid_reg <= rsp_valid_next;
            k_reg         <= k_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        opn_reg      <= opn_next;
        opd_reg      <= opd_next;
        res_num_reg  <= res_num_next;
        res_den_reg  <= res_den_next;
        prod_reg     <= prod_next;
        neg_reg      <= neg_next;
        ov_reg       <= ov_next;
        zerr_reg     <= zerr_next;
        ga_reg       <= ga_next;
        gb_reg       <= gb_next;
        rsp_num_reg  <= rsp_num_next;
        rsp_den_reg  <= rsp_den_next;
        rsp_ov_reg   <= rsp_ov_next;
        rsp_zerr_reg <= rsp_zerr_next;
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.result_num     = rsp_num_reg;
    assign rsp.result_den     = rsp_den_reg;
    assign rsp.overflow       = rsp_ov_reg;
    assign rsp.zero_den_error = rsp_zerr_reg;

endmodule

// ===== hdl/raa_checker.sv =====
`include "rational_accumulator_alu_unit_assert.svh"

// Port-level checks for the rational accumulator
module raa_checker (
    input logic                            clk,
    input logic                            rst_n,
    input logic                            req_valid,
    input logic                            req_ready,
    input logic                            rsp_valid,
    input logic                            rsp_ready,
    input logic signed [raa_pkg::IO_W-1:0] rsp_num,
    input logic signed [raa_pkg::IO_W-1:0] rsp_den,
    input logic                            rsp_overflow,
    input logic                            rsp_zerr
);
    import raa_pkg::*;

    // one command at a time: no request taken right after a transaction
    `RAA_ASSERT_NEXT(a_busy_after_req, req_valid && req_ready, !req_ready)

    // a stalled result holds
    `RAA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_num) && $stable(rsp_den))

    // overflow and zero_den_error are never flagged together
    `RAA_ASSERT_IMPL(a_flags_exclusive, rsp_valid, !(rsp_overflow && rsp_zerr))

    // a zero denominator error returns the zero denominator untouched
    `RAA_ASSERT_IMPL(a_zerr_den_zero, rsp_valid && rsp_zerr, rsp_den == '0)

endmodule

bind rational_accumulator_alu_unit raa_checker u_raa_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .req_valid    (req.valid),
    .req_ready    (req.ready),
    .rsp_valid    (rsp.valid),
    .rsp_ready    (rsp.ready),
    .rsp_num      (rsp.result_num),
    .rsp_den      (rsp.result_den),
    .rsp_overflow (rsp.overflow),
    .rsp_zerr     (rsp.zero_den_error)
);

// ===== bench/rational_accumulator_alu_unit_tb.sv =====
module rational_accumulator_alu_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import raa_pkg::*;

    localparam int ACC_WIDTH    = 32;
    localparam int RANDOM_ITEMS = 1800;
    localparam int GAP_MAX      = 11;
    localparam int MAX_REPORTS  = 10;
    localparam int TAIL_CYCLES  = 4 * (ACC_WIDTH + 2) + 20;
    localparam int N_ROWS       = 25;

    // Codes the block treats as no-ops
    localparam logic [CMD_W-1:0] CMD_SPARE6 = 3'd6;
    localparam logic [CMD_W-1:0] CMD_SPARE7 = 3'd7;

    localparam logic signed [IO_W-1:0] S_MAX = 32'sh7fff_ffff;
    localparam logic signed [IO_W-1:0] S_MIN = 32'sh8000_0000;
    localparam longint                 L_MAX = 64'sd2147483647;
    localparam longint                 L_MIN = -64'sd2147483648;

    typedef struct {
        logic signed [IO_W-1:0] num;
        logic signed [IO_W-1:0] den;
        logic                   overflow;
        logic                   zero_den_error;
    } frac_result_t;

    typedef struct {
        logic [CMD_W-1:0]       cmd;
        logic signed [IO_W-1:0] num;
        logic signed [IO_W-1:0] den;
        bit                     typed;
        frac_result_t           want;
    } stim_row_t;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    raa_req_if req_bus ();
    raa_rsp_if rsp_bus ();

    rational_accumulator_alu_unit #(
        .WIDTH (ACC_WIDTH)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_bus),
        .rsp   (rsp_bus)
    );

    // Shadow accumulator and expected results in flight
    logic signed [IO_W-1:0] track_num = 32'sd0;
    logic signed [IO_W-1:0] track_den = 32'sd1;
    frac_result_t           expected_fracs [$];

    bit steady_flow = 1'b0;
    int fail_count      = 0;
    int results_checked = 0;
    int overflow_seen   = 0;
    int zero_den_seen   = 0;
    int cmd_count [0:7] = '{default: 0};

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Hard stop in case the block hangs
    initial
    begin
        #100_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic signed [IO_W-1:0] wrap32(input longint v);
        return v[IO_W-1:0];
    endfunction

    function automatic bit escapes(input longint v);
        return (v > L_MAX) || (v < L_MIN);
    endfunction

    // Apply one command to the shadow accumulator and return what the block should send
    function automatic frac_result_t rational_step(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [IO_W-1:0] on,
                                                   input logic signed [IO_W-1:0] od);
        frac_result_t           r;
        longint                 pa, pb, pd, sum, mag_n, mag_d, x, y, t;
        logic signed [IO_W-1:0] n, d;
        r.overflow       = 1'b0;
        r.zero_den_error = 1'b0;
        n = track_num;
        d = track_den;
        case (cmd)
            CMD_LOAD:
            begin
                n = on;
                d = od;
            end
            CMD_ADD, CMD_SUB:
            begin
                pa = longint'(track_num) * longint'(od);
                pb = longint'(track_den) * longint'(on);
                pd = longint'(track_den) * longint'(od);
                if (cmd == CMD_ADD)
                    sum = longint'(wrap32(pa)) + longint'(wrap32(pb));
                else
                    sum = longint'(wrap32(pa)) - longint'(wrap32(pb));
                n = wrap32(sum);
                d = wrap32(pd);
                r.overflow = escapes(pa) | escapes(pb) | escapes(sum) | escapes(pd);
            end
            CMD_MUL, CMD_DIV:
            begin
                // divide is multiply by the flipped operand
                if (cmd == CMD_MUL)
                begin
                    pa = longint'(track_num) * longint'(on);
                    pb = longint'(track_den) * longint'(od);
                end
                else
                begin
                    pa = longint'(track_num) * longint'(od);
                    pb = longint'(track_den) * longint'(on);
                end
                n = wrap32(pa);
                d = wrap32(pb);
                r.overflow = escapes(pa) | escapes(pb);
            end
            CMD_REDUCE:
            begin
                mag_n = (track_num < 0) ? -longint'(track_num) : longint'(track_num);
                mag_d = (track_den < 0) ? -longint'(track_den) : longint'(track_den);
                if (mag_d == 0)
                    r.zero_den_error = 1'b1;
                else if (mag_n == 0)
                begin
                    n = 32'sd0;
                    d = 32'sd1;
                end
                else
                begin
                    x = mag_n;
                    y = mag_d;
                    while (y != 0)
                    begin
                        t = x % y;
                        x = y;
                        y = t;
                    end
                    // each part keeps its own sign
                    n = wrap32((track_num < 0) ? -(mag_n / x) : (mag_n / x));
                    d = wrap32((track_den < 0) ? -(mag_d / x) : (mag_d / x));
                end
            end
            default:
            begin
            end
        endcase
        track_num = n;
        track_den = d;
        r.num = n;
        r.den = d;
        return r;
    endfunction

    function automatic int idle_cycles();
        if (steady_flow)
            return 0;
        return $urandom_range(0, GAP_MAX);
    endfunction

    function automatic logic [CMD_W-1:0] pick_command();
        int r;
        r = $urandom_range(0, 99);
        if (r < 15)
            return CMD_LOAD;
        else if (r < 35)
            return CMD_ADD;
        else if (r < 50)
            return CMD_SUB;
        else if (r < 65)
            return CMD_MUL;
        else if (r < 80)
            return CMD_DIV;
        else if (r < 97)
            return CMD_REDUCE;
        else if (r < 99)
            return CMD_SPARE6;
        return CMD_SPARE7;
    endfunction

    // Small values so GCDs and sums stay meaningful, plus 16-bit values, extremes and full range
    function automatic logic signed [IO_W-1:0] pick_operand();
        case ($urandom_range(0, 9))
            0, 1, 2, 3: return $signed(32'($urandom_range(0, 64))) - 32'sd32;
            4:
            begin
                case ($urandom_range(0, 4))
                    0:       return 32'sd0;
                    1:       return 32'sd1;
                    2:       return -32'sd1;
                    3:       return S_MAX;
                    default: return S_MIN;
                endcase
            end
            5:       return $signed(32'($urandom_range(0, 65535))) - 32'sd32768;
            default: return $urandom();
        endcase
    endfunction

    task automatic record_failure(input string what, input frac_result_t want,
                                  input frac_result_t got);
        fail_count++;
        if (fail_count <= MAX_REPORTS)
            $display("%0t %s: expected %0d/%0d ov=%0b zde=%0b, got %0d/%0d ov=%0b zde=%0b",
                     $time, what, want.num, want.den, want.overflow, want.zero_den_error,
                     got.num, got.den, got.overflow, got.zero_den_error);
    endtask

    // Present one request and hold it until the block takes it
    task automatic issue_command(input logic [CMD_W-1:0] cmd,
                                 input logic signed [IO_W-1:0] on,
                                 input logic signed [IO_W-1:0] od);
        int gap;
        gap = idle_cycles();
        if (gap > 0)
        begin
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid       <= 1'b1;
        req_bus.command     <= cmd;
        req_bus.operand_num <= on;
        req_bus.operand_den <= od;
        @(posedge clk);
        while (!req_bus.ready)
            @(posedge clk);
        cmd_count[cmd]++;
    endtask

    // Sender holds off until every outstanding result is back
    task automatic hold_until_drained();
        req_bus.valid <= 1'b0;
        @(posedge clk);
        while (expected_fracs.size() != 0)
            @(posedge clk);
    endtask

    // Response side: random back-pressure, compare each transaction with the oldest expectation
    initial
    begin : response_side
        frac_result_t got;
        frac_result_t want;
        int           stall;
        rsp_bus.ready <= 1'b0;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = idle_cycles();
            if (stall > 0)
            begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            rsp_bus.ready <= 1'b1;
            @(posedge clk);
            while (!rsp_bus.valid)
                @(posedge clk);
            got.num            = rsp_bus.result_num;
            got.den            = rsp_bus.result_den;
            got.overflow       = rsp_bus.overflow;
            got.zero_den_error = rsp_bus.zero_den_error;
            if (expected_fracs.size() == 0)
            begin
                want = '{default: '0};
                record_failure("result with nothing outstanding", want, got);
            end
            else
            begin
                want = expected_fracs.pop_front();
                results_checked++;
                overflow_seen += want.overflow;
                zero_den_seen += want.zero_den_error;
                if (got.num !== want.num || got.den !== want.den ||
                    got.overflow !== want.overflow ||
                    got.zero_den_error !== want.zero_den_error)
                    record_failure("mismatch", want, got);
            end
        end
    end

    initial
    begin : stimulus
        stim_row_t              rows [N_ROWS];
        frac_result_t           pred;
        logic [CMD_W-1:0]       cmd;
        logic signed [IO_W-1:0] on, od;
        int                     arith_sent;
        int                     items_sent;

        req_bus.valid       <= 1'b0;
        req_bus.command     <= CMD_LOAD;
        req_bus.operand_num <= 32'sd0;
        req_bus.operand_den <= 32'sd0;

        // Directed part: typed rows are the obvious ones, the rest go through the predictor
        rows = '{
            '{CMD_REDUCE, S_MAX, -32'sd1, 1'b1, '{32'sd0, 32'sd1, 1'b0, 1'b0}},
            '{CMD_SPARE6, 32'sd123, -32'sd456, 1'b1, '{32'sd0, 32'sd1, 1'b0, 1'b0}},
            '{CMD_SPARE7, S_MIN, S_MAX, 1'b1, '{32'sd0, 32'sd1, 1'b0, 1'b0}},
            '{CMD_LOAD, S_MAX, S_MIN, 1'b1, '{S_MAX, S_MIN, 1'b0, 1'b0}},
            '{CMD_LOAD, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b0}},
            '{CMD_REDUCE, 32'sd0, 32'sd0, 1'b1, '{32'sd0, 32'sd0, 1'b0, 1'b1}},
            '{CMD_LOAD, 32'sd5, 32'sd0, 1'b1, '{32'sd5, 32'sd0, 1'b0, 1'b0}},
            '{CMD_REDUCE, S_MIN, S_MIN, 1'b1, '{32'sd5, 32'sd0, 1'b0, 1'b1}},
            '{CMD_LOAD, 32'sd12, -32'sd18, 1'b1, '{32'sd12, -32'sd18, 1'b0, 1'b0}},
            '{CMD_REDUCE, 32'sd0, 32'sd0, 1'b1, '{32'sd2, -32'sd3, 1'b0, 1'b0}},
            '{CMD_LOAD, S_MIN, 32'sd2, 1'b1, '{S_MIN, 32'sd2, 1'b0, 1'b0}},
            '{CMD_REDUCE, 32'sd0, 32'sd0, 1'b1, '{-32'sd1073741824, 32'sd1, 1'b0, 1'b0}},
            '{CMD_LOAD, S_MIN, S_MIN, 1'b1, '{S_MIN, S_MIN, 1'b0, 1'b0}},
            '{CMD_REDUCE, 32'sd0, 32'sd0, 1'b1, '{-32'sd1, -32'sd1, 1'b0, 1'b0}},
            '{CMD_ADD, 32'sd1, 32'sd3, 1'b0, '{default: '0}},
            '{CMD_MUL, S_MAX, S_MAX, 1'b0, '{default: '0}},
            '{CMD_LOAD, 32'sd65536, 32'sd65536, 1'b1, '{32'sd65536, 32'sd65536, 1'b0, 1'b0}},
            '{CMD_MUL, 32'sd65536, 32'sd65536, 1'b1, '{32'sd0, 32'sd0, 1'b1, 1'b0}},
            '{CMD_LOAD, S_MIN, 32'sd1, 1'b1, '{S_MIN, 32'sd1, 1'b0, 1'b0}},
            '{CMD_SUB, 32'sd1, 32'sd1, 1'b1, '{S_MAX, 32'sd1, 1'b1, 1'b0}},
            '{CMD_DIV, 32'sd0, 32'sd5, 1'b0, '{default: '0}},
            '{CMD_REDUCE, 32'sd0, 32'sd0, 1'b0, '{default: '0}},
            '{CMD_LOAD, -32'sd6, 32'sd4, 1'b1, '{-32'sd6, 32'sd4, 1'b0, 1'b0}},
            '{CMD_REDUCE, 32'sd0, 32'sd0, 1'b1, '{-32'sd3, 32'sd2, 1'b0, 1'b0}},
            '{CMD_DIV, -32'sd7, -32'sd9, 1'b0, '{default: '0}}
        };

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        foreach (rows[i])
        begin
            issue_command(rows[i].cmd, rows[i].num, rows[i].den);
            pred = rational_step(rows[i].cmd, rows[i].num, rows[i].den);
            expected_fracs.push_back(rows[i].typed ? rows[i].want : pred);
        end

        // Random part; no-op codes do not count toward the total
        arith_sent = 0;
        items_sent = 0;
        while (arith_sent < RANDOM_ITEMS)
        begin
            steady_flow = (items_sent % 300) >= 230;
            if (items_sent % 450 == 449)
                hold_until_drained();
            cmd = pick_command();
            on  = pick_operand();
            od  = pick_operand();
            issue_command(cmd, on, od);
            expected_fracs.push_back(rational_step(cmd, on, od));
            items_sent++;
            if (cmd != CMD_SPARE6 && cmd != CMD_SPARE7)
                arith_sent++;
        end

        req_bus.valid <= 1'b0;
        steady_flow = 1'b0;
        while (expected_fracs.size() != 0)
            @(posedge clk);
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Sent load %0d, add %0d, sub %0d, mul %0d, div %0d, reduce %0d, no-op %0d",
                 cmd_count[CMD_LOAD], cmd_count[CMD_ADD], cmd_count[CMD_SUB],
                 cmd_count[CMD_MUL], cmd_count[CMD_DIV], cmd_count[CMD_REDUCE],
                 cmd_count[CMD_SPARE6] + cmd_count[CMD_SPARE7]);
        $display("Checked %0d results (%0d with overflow, %0d with zero denominator), %0d failures",
                 results_checked, overflow_seen, zero_den_seen, fail_count);
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/raa_pkg.sv
hdl/raa_if.sv
hdl/raa_iter_unit.sv
hdl/rational_accumulator_alu_unit.sv
hdl/raa_checker.sv
bench/rational_accumulator_alu_unit_tb.sv
